// ===== rtl/gwpa_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gwpa_pkg
// Shared constants for the gated window pulse accumulator: field widths,
// configuration register indexes and item opcodes.
// -----------------------------------------------------------------------------
package gwpa_pkg;

  // Fixed field widths.
  localparam int WC_W    = 9;         // window_count register
  localparam int WT_W    = 12;        // window_time register
  localparam int TICK_W  = WT_W + 1;  // window tick counter, holds 2*window_time
  localparam int CNT_W   = 16;        // per-window pulse counters
  localparam int BIN_W   = 32;        // accumulated bins
  localparam int FIRE_W  = 16;        // fire counter
  localparam int RIDX_W  = 8;         // read index field
  localparam int CFG_W   = 12;        // configuration write data
  localparam int CIDX_W  = 2;         // configuration register index

  // Reset values of the configuration registers (before clamping).
  localparam int WC_RESET = 64;
  localparam int WT_RESET = 64;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_WINDOW_COUNT = 2'd0,
    CFG_WINDOW_TIME  = 2'd1,
    CFG_GEN_ENABLED  = 2'd2
  } cfg_reg_t;

  // Item opcodes.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

endpackage

// ===== rtl/gwpa_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gwpa_ram
// Generic single-clock RAM with one write port and one registered read port.
// -----------------------------------------------------------------------------
module gwpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in the array, read returns the old contents on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gated_window_pulse_accumulator_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gated_window_pulse_accumulator_unit
// Two-channel multichannel scaler. Fires start sweeps of timed windows; each
// closed window adds its pulse counts into a pair of 32-bit bins in RAM.
// Results pass through the memory stage register and the output queue.
// Throughput: one transaction per cycle while the output queue has room, set by
// the bin read-modify-write (read issued on accept, sum written back from the memory stage).
// Reset: after rst the bin RAM is cleared one entry per cycle over all NUM_BINS
// entries, with in_ready low; configuration writes are taken during that pass.
// -----------------------------------------------------------------------------
module gated_window_pulse_accumulator_unit
  import gwpa_pkg::*;
#(
  parameter int NUM_BINS        = 256,
  parameter int MAX_WINDOW_TIME = 2048
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_write,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // Input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic                fire,
  input  logic                pulse_b,
  input  logic                pulse_m,
  input  logic [RIDX_W-1:0]   read_index,
  // Output channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BIN_W-1:0]    bin_b,
  output logic [BIN_W-1:0]    bin_m,
  output logic                window_closed,
  output logic                sweep_active,
  output logic [FIRE_W-1:0]   fire_total
);

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CMP_W = (IDX_W + 1 > WC_W) ? IDX_W + 1 : WC_W;
  localparam int WC_HI = (NUM_BINS > 511) ? 511 : NUM_BINS;
  localparam int WT_HI = (MAX_WINDOW_TIME > 4095) ? 4095 : MAX_WINDOW_TIME;
  localparam int WC_RST = (WC_RESET > WC_HI) ? WC_HI : WC_RESET;
  localparam int WT_RST = (WT_RESET > WT_HI) ? WT_HI : WT_RESET;
  localparam int Q_DEPTH = 3;

  // Item in the memory stage.
  typedef struct packed {
    logic              is_read;
    logic              is_close;
    logic              in_range;
    logic [IDX_W-1:0]  addr;
    logic [CNT_W-1:0]  cnt_b;
    logic [CNT_W-1:0]  cnt_m;
    logic              active;
    logic [FIRE_W-1:0] fires;
  } mem_stage_t;

  // Result as queued for the output.
  typedef struct packed {
    logic [BIN_W-1:0]  b;
    logic [BIN_W-1:0]  m;
    logic              closed;
    logic              active;
    logic [FIRE_W-1:0] fires;
  } result_t;

  // Configuration registers.
  logic [WC_W-1:0]   window_count;
  logic [WT_W-1:0]   window_time;
  logic              gen_enabled;

  // Sweep state.
  logic [IDX_W-1:0]  bin_index;
  logic [WC_W-1:0]   sweep_length;
  logic [WT_W-1:0]   win_half;
  logic [TICK_W-1:0] window_ticks;
  logic [CNT_W-1:0]  count_b;
  logic [CNT_W-1:0]  count_m;
  logic              running;
  logic [FIRE_W-1:0] fires;

  logic [IDX_W-1:0]  bin_index_next;
  logic [WC_W-1:0]   sweep_length_next;
  logic [WT_W-1:0]   win_half_next;
  logic [TICK_W-1:0] window_ticks_next;
  logic [CNT_W-1:0]  count_b_next;
  logic [CNT_W-1:0]  count_m_next;
  logic              running_next;
  logic [FIRE_W-1:0] fires_next;

  // Clearing pass.
  logic              clr_active;
  logic [IDX_W-1:0]  clr_addr;

  // Pipeline and queue.
  logic              accept;
  logic              s1_valid;
  mem_stage_t        s1;
  mem_stage_t        s0_item;
  logic [IDX_W-1:0]  rd_addr;
  logic              s0_close;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [2*BIN_W-1:0]       ram_wdata;
  logic [2*BIN_W-1:0]       ram_rdata;

  logic                     wr_q_valid;
  logic [IDX_W-1:0]         wr_q_addr;
  logic [2*BIN_W-1:0]       wr_q_data;
  logic [2*BIN_W-1:0]       old_pair;
  logic [BIN_W-1:0]         sum_b;
  logic [BIN_W-1:0]         sum_m;
  result_t                  s1_result;

  result_t                  q_mem [Q_DEPTH];
  logic [1:0]               q_wr;
  logic [1:0]               q_rd;
  logic [1:0]               q_count;
  logic                     q_push;
  logic                     q_pop;

  // Handshake: room for everything in flight plus this transaction.
  assign accept   = in_valid && in_ready;
  assign in_ready = !clr_active &&
                    ((3'(q_count) + 3'(s1_valid)) < 3'(Q_DEPTH));

  // Configuration writes with clamping.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= WC_W'(WC_RST);
      window_time  <= WT_W'(WT_RST);
      gen_enabled  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_COUNT: begin
          if (cfg_data[WC_W-1:0] < WC_W'(2)) begin
            window_count <= WC_W'(2);
          end else if (32'(cfg_data[WC_W-1:0]) > WC_HI) begin
            window_count <= WC_W'(WC_HI);
          end else begin
            window_count <= cfg_data[WC_W-1:0];
          end
        end
        CFG_WINDOW_TIME: begin
          if (cfg_data[WT_W-1:0] < WT_W'(2)) begin
            window_time <= WT_W'(2);
          end else if (32'(cfg_data[WT_W-1:0]) > WT_HI) begin
            window_time <= WT_W'(WT_HI);
          end else begin
            window_time <= cfg_data[WT_W-1:0];
          end
        end
        CFG_GEN_ENABLED: begin
          gen_enabled <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Tick processing: restart on fire, count pulses, close windows.
  always_comb begin
    logic [IDX_W-1:0]  idx0;
    logic [WC_W-1:0]   len0;
    logic [WT_W-1:0]   half0;
    logic [TICK_W-1:0] ticks0;
    logic [CNT_W-1:0]  cb0;
    logic [CNT_W-1:0]  cm0;
    logic              run0;
    logic [TICK_W-1:0] ticks1;
    logic [CNT_W-1:0]  cb1;
    logic [CNT_W-1:0]  cm1;

    idx0   = fire ? '0 : bin_index;
    len0   = fire ? window_count : sweep_length;
    half0  = fire ? window_time : win_half;
    ticks0 = fire ? '0 : window_ticks;
    cb0    = fire ? '0 : count_b;
    cm0    = fire ? '0 : count_m;
    run0   = fire || running;
    ticks1 = ticks0 + TICK_W'(1);
    cb1    = cb0 + CNT_W'(pulse_b);
    cm1    = cm0 + CNT_W'(pulse_m);

    bin_index_next    = bin_index;
    sweep_length_next = sweep_length;
    win_half_next     = win_half;
    window_ticks_next = window_ticks;
    count_b_next      = count_b;
    count_m_next      = count_m;
    running_next      = running;
    fires_next        = fires;
    s0_close          = 1'b0;

    if (accept && opcode == OP_TICK) begin
      bin_index_next    = idx0;
      sweep_length_next = len0;
      win_half_next     = half0;
      window_ticks_next = ticks0;
      count_b_next      = cb0;
      count_m_next      = cm0;
      running_next      = run0;
      if (fire && gen_enabled) begin
        fires_next = fires + FIRE_W'(1);
      end
      if (run0) begin
        count_b_next      = cb1;
        count_m_next      = cm1;
        window_ticks_next = ticks1;
        if (ticks1 >= {half0, 1'b0}) begin
          s0_close          = 1'b1;
          count_b_next      = '0;
          count_m_next      = '0;
          window_ticks_next = '0;
          bin_index_next    = idx0 + IDX_W'(1);
          if ((CMP_W'(idx0) + CMP_W'(1)) >= CMP_W'(len0)) begin
            running_next = 1'b0;
          end
        end
      end
    end

    // Item handed to the memory stage.
    s0_item.is_read  = (opcode == OP_READ);
    s0_item.is_close = s0_close;
    s0_item.in_range = (32'(read_index) < NUM_BINS);
    s0_item.addr     = (opcode == OP_READ) ? IDX_W'(32'(read_index)) : idx0;
    s0_item.cnt_b    = cb1;
    s0_item.cnt_m    = cm1;
    s0_item.active   = running_next;
    s0_item.fires    = fires_next;
    rd_addr          = s0_item.addr;
  end

  // Sweep state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_index    <= '0;
      sweep_length <= WC_W'(WC_RST);
      win_half     <= WT_W'(WT_RST);
      window_ticks <= '0;
      count_b      <= '0;
      count_m      <= '0;
      running      <= 1'b0;
      fires        <= '0;
    end else begin
      bin_index    <= bin_index_next;
      sweep_length <= sweep_length_next;
      win_half     <= win_half_next;
      window_ticks <= window_ticks_next;
      count_b      <= count_b_next;
      count_m      <= count_m_next;
      running      <= running_next;
      fires        <= fires_next;
    end
  end

  // Memory stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1 <= s0_item;
    end
  end

  // Clearing pass over the bin RAM after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(NUM_BINS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Forward the previous cycle's write, which the RAM read did not see yet.
  assign old_pair = (wr_q_valid && wr_q_addr == s1.addr) ? wr_q_data : ram_rdata;
  assign sum_b    = old_pair[2*BIN_W-1:BIN_W] + BIN_W'(s1.cnt_b);
  assign sum_m    = old_pair[BIN_W-1:0] + BIN_W'(s1.cnt_m);

  // Bin write-back and result formation.
  always_comb begin
    s1_result.closed = s1.is_close;
    s1_result.active = s1.active;
    s1_result.fires  = s1.fires;
    s1_result.b      = '0;
    s1_result.m      = '0;
    if (s1.is_read) begin
      if (s1.in_range) begin
        s1_result.b = old_pair[2*BIN_W-1:BIN_W];
        s1_result.m = old_pair[BIN_W-1:0];
      end
    end else if (s1.is_close) begin
      s1_result.b = sum_b;
      s1_result.m = sum_m;
    end

    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid && s1.is_close && !s1.is_read;
      ram_waddr = s1.addr;
      ram_wdata = {sum_b, sum_m};
    end
  end

  // Last write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q_valid <= 1'b0;
    end else begin
      wr_q_valid <= ram_we;
    end
    wr_q_addr <= ram_waddr;
    wr_q_data <= ram_wdata;
  end

  gwpa_ram #(
    .WIDTH (2 * BIN_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Output queue of results.
  assign q_push = s1_valid;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wr <= (q_wr == 2'(Q_DEPTH - 1)) ? '0 : q_wr + 2'd1;
      end
      if (q_pop) begin
        q_rd <= (q_rd == 2'(Q_DEPTH - 1)) ? '0 : q_rd + 2'd1;
      end
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
    if (q_push) begin
      q_mem[q_wr] <= s1_result;
    end
  end

  assign out_valid     = (q_count != '0);
  assign bin_b         = q_mem[q_rd].b;
  assign bin_m         = q_mem[q_rd].m;
  assign window_closed = q_mem[q_rd].closed;
  assign sweep_active  = q_mem[q_rd].active;
  assign fire_total    = q_mem[q_rd].fires;

  // No transaction is taken while the RAM is being cleared.
  assert property (@(posedge clk) disable iff (rst) clr_active |-> !in_ready)
    else $error("input accepted during bin clearing pass");

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk) disable iff (rst) q_count <= 2'(Q_DEPTH))
    else $error("result queue overflow");

  // A running sweep never lets the tick counter reach the window length.
  assert property (@(posedge clk) disable iff (rst)
      running |-> (window_ticks < {win_half, 1'b0}))
    else $error("window tick counter ran past window length");

  // A result pushed into a full queue with no pop at the same time would be lost.
  assert property (@(posedge clk) disable iff (rst)
      (q_count == 2'(Q_DEPTH)) |-> !(q_push && !q_pop))
    else $error("result pushed into full queue");

endmodule
